// ===== hdl/multi_channel_pwm_timer_assert.svh =====
// assertion macros shared by the timer checker
// each macro clocks on clk and is disabled while rst_n is low
`ifndef MULTI_CHANNEL_PWM_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_PWM_TIMER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcpt_pkg.sv =====
`default_nettype none

package mcpt_pkg;

    // fixed field widths
    localparam int CMD_W        = 2;
    localparam int CHAN_IDX_W   = 2;
    localparam int VALUE_W      = 16;
    localparam int PWM_W        = 4;
    localparam int PERIOD_NOW_W = 16;
    localparam int PRESCALE_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // parameter defaults
    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_COUNT_WIDTH = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_DUTY   = 2'd1,
        CMD_PERIOD = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE   = 2'd0,
        CFG_ENABLE     = 2'd1,
        CFG_POLARITY   = 2'd2,
        CFG_COMPLEMENT = 2'd3
    } cfg_idx_t;

    // decoded request, valid only in the accept cycle
    typedef struct packed {
        logic tick;
        logic duty_wr;
        logic period_wr;
    } mcpt_op_t;

endpackage

`default_nettype wire

// ===== hdl/mcpt_counter.sv =====
`default_nettype none

module mcpt_counter #(
    parameter int COUNT_WIDTH = mcpt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mcpt_pkg::mcpt_op_t              op,
    input  wire logic [COUNT_WIDTH-1:0]          value_cw,
    input  wire logic [mcpt_pkg::PRESCALE_W-1:0] prescale_divide,
    output logic [COUNT_WIDTH-1:0]               main_count_next,
    output logic [COUNT_WIDTH-1:0]               period_preload_next,
    output logic                                 update
);
    import mcpt_pkg::*;

    logic [PRESCALE_W-1:0]  prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] main_count_reg;
    logic [COUNT_WIDTH-1:0] period_preload_reg;
    logic [COUNT_WIDTH-1:0] period_active_reg, period_active_next;
    logic                   prescale_wrap;
    logic                   count_wrap;
    logic                   step;

    always_comb
    begin
        prescale_wrap = (prescale_count_reg >= prescale_divide);
        count_wrap    = (main_count_reg >= period_active_reg);
        step          = op.tick & prescale_wrap;
        update        = step & count_wrap;

        prescale_count_next = prescale_count_reg;
        if (op.tick)
        begin
            prescale_count_next = prescale_wrap ? '0 : prescale_count_reg + PRESCALE_W'(1);
        end

        main_count_next = main_count_reg;
        if (step)
        begin
            main_count_next = count_wrap ? '0 : main_count_reg + COUNT_WIDTH'(1);
        end

        period_active_next  = update ? period_preload_reg : period_active_reg;
        period_preload_next = op.period_wr ? value_cw : period_preload_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            main_count_reg     <= '0;
            period_preload_reg <= '0;
            period_active_reg  <= '0;
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            main_count_reg     <= main_count_next;
            period_preload_reg <= period_preload_next;
            period_active_reg  <= period_active_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcpt_channels.sv =====
`default_nettype none

module mcpt_channels #(
    parameter int CHANNELS    = mcpt_pkg::DEF_CHANNELS,
    parameter int COUNT_WIDTH = mcpt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mcpt_pkg::mcpt_op_t              op,
    input  wire logic [mcpt_pkg::CHAN_IDX_W-1:0] channel,
    input  wire logic [COUNT_WIDTH-1:0]          value_cw,
    input  wire logic                            update,
    input  wire logic [COUNT_WIDTH-1:0]          main_count_next,
    input  wire logic [mcpt_pkg::PWM_W-1:0]      enable_mask,
    input  wire logic [mcpt_pkg::PWM_W-1:0]      polarity_mask,
    input  wire logic [mcpt_pkg::PWM_W-1:0]      complementary_mask,
    output logic [mcpt_pkg::PWM_W-1:0]           pwm_out_next,
    output logic [mcpt_pkg::PWM_W-1:0]           pwm_out_inv_next
);
    import mcpt_pkg::*;

    genvar n;
    generate
        for (n = 0; n < PWM_W; n++)
        begin : g_ch
            if (n < CHANNELS)
            begin : g_live
                logic [COUNT_WIDTH-1:0] duty_preload_reg, duty_preload_next;
                logic [COUNT_WIDTH-1:0] duty_active_reg, duty_active_next;
                logic                   ref_level;

                always_comb
                begin
                    duty_preload_next = duty_preload_reg;
                    if (op.duty_wr && (channel == CHAN_IDX_W'(n)))
                    begin
                        duty_preload_next = value_cw;
                    end
                    duty_active_next = update ? duty_preload_reg : duty_active_reg;
                    // mode 1: high while the counter is below the duty
                    ref_level = (main_count_next < duty_active_next);
                    pwm_out_next[n] = (ref_level ^ polarity_mask[n]) & enable_mask[n];
                    pwm_out_inv_next[n] = ~ref_level & enable_mask[n]
                                          & complementary_mask[n];
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        duty_preload_reg <= '0;
                        duty_active_reg  <= '0;
                    end
                    else
                    begin
                        duty_preload_reg <= duty_preload_next;
                        duty_active_reg  <= duty_active_next;
                    end
                end
            end
            else
            begin : g_unused
                assign pwm_out_next[n]     = 1'b0;
                assign pwm_out_inv_next[n] = 1'b0;
            end
        end
    endgenerate

endmodule

`default_nettype wire

// ===== hdl/multi_channel_pwm_timer.sv =====
// latency: a request's result is registered and shown the cycle after it is accepted
// throughput: one request per cycle unless a held result stalls in_ready; the
//   prescaler, counter and channel compares are combinational from state to result register
// reset: rst_n is asynchronous, active low; counters, preloads, active values,
//   configuration and the output valid all clear to zero
`default_nettype none

module multi_channel_pwm_timer #(
    parameter int CHANNELS    = mcpt_pkg::DEF_CHANNELS,
    parameter int COUNT_WIDTH = mcpt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mcpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mcpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mcpt_pkg::CMD_W-1:0]        cmd,
    input  wire logic [mcpt_pkg::CHAN_IDX_W-1:0]   channel,
    input  wire logic [mcpt_pkg::VALUE_W-1:0]      value,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mcpt_pkg::PWM_W-1:0]             pwm_out,
    output logic [mcpt_pkg::PWM_W-1:0]             pwm_out_inv,
    output logic                                   update_event,
    output logic [mcpt_pkg::PERIOD_NOW_W-1:0]      period_now
);
    import mcpt_pkg::*;

    // configuration registers
    logic [PRESCALE_W-1:0] prescale_divide_reg;
    logic [PWM_W-1:0]      enable_mask_reg;
    logic [PWM_W-1:0]      polarity_mask_reg;
    logic [PWM_W-1:0]      complementary_mask_reg;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [PWM_W-1:0]        pwm_out_reg;
    logic [PWM_W-1:0]        pwm_out_inv_reg;
    logic                    update_event_reg;
    logic [PERIOD_NOW_W-1:0] period_now_reg;

    logic                   accept;
    mcpt_op_t               op;
    logic [COUNT_WIDTH-1:0] value_cw;
    logic [COUNT_WIDTH-1:0] main_count_next;
    logic [COUNT_WIDTH-1:0] period_preload_next;
    logic                   update;
    logic [PWM_W-1:0]       pwm_out_next;
    logic [PWM_W-1:0]       pwm_out_inv_next;

    // a new request is taken whenever the result slot is empty or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // decode the request; unused command code does nothing
    always_comb
    begin
        op.tick      = accept && (cmd == CMD_TICK);
        op.duty_wr   = accept && (cmd == CMD_DUTY);
        op.period_wr = accept && (cmd == CMD_PERIOD);
    end

    // written values are kept to the counter width
    assign value_cw = COUNT_WIDTH'(value);

    // prescaler, main counter and period shadow
    mcpt_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .value_cw            (value_cw),
        .prescale_divide     (prescale_divide_reg),
        .main_count_next     (main_count_next),
        .period_preload_next (period_preload_next),
        .update              (update)
    );

    // duty shadows and per channel compare against the updated count
    mcpt_channels #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_channels (
        .clk                (clk),
        .rst_n              (rst_n),
        .op                 (op),
        .channel            (channel),
        .value_cw           (value_cw),
        .update             (update),
        .main_count_next    (main_count_next),
        .enable_mask        (enable_mask_reg),
        .polarity_mask      (polarity_mask_reg),
        .complementary_mask (complementary_mask_reg),
        .pwm_out_next       (pwm_out_next),
        .pwm_out_inv_next   (pwm_out_inv_next)
    );

    // configuration writes, taken in any cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_divide_reg    <= '0;
            enable_mask_reg        <= '0;
            polarity_mask_reg      <= '0;
            complementary_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRESCALE:   prescale_divide_reg    <= PRESCALE_W'(cfg_data);
                CFG_ENABLE:     enable_mask_reg        <= PWM_W'(cfg_data);
                CFG_POLARITY:   polarity_mask_reg      <= PWM_W'(cfg_data);
                CFG_COMPLEMENT: complementary_mask_reg <= PWM_W'(cfg_data);
                default:        ;
            endcase
        end
    end

    // result slot valid: set on accept, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pwm_out_reg      <= pwm_out_next;
            pwm_out_inv_reg  <= pwm_out_inv_next;
            update_event_reg <= update;
            period_now_reg   <= PERIOD_NOW_W'(period_preload_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pwm_out      = pwm_out_reg;
    assign pwm_out_inv  = pwm_out_inv_reg;
    assign update_event = update_event_reg;
    assign period_now   = period_now_reg;

endmodule

`default_nettype wire

// ===== hdl/mcpt_checker.sv =====
`default_nettype none
`include "multi_channel_pwm_timer_assert.svh"

module mcpt_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic [mcpt_pkg::CMD_W-1:0]        cmd,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [mcpt_pkg::PWM_W-1:0]        pwm_out,
    input wire logic [mcpt_pkg::PWM_W-1:0]        pwm_out_inv,
    input wire logic                              update_event,
    input wire logic [mcpt_pkg::PERIOD_NOW_W-1:0] period_now
);
    import mcpt_pkg::*;

    // empty result slot never holds off a request
    `PWM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "in_ready low with empty result slot")

    // every accepted request gives a result the next cycle
    `PWM_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted request gave no result")

    // only a tick can wrap the counter
    `PWM_ASSERT_NEXT(a_update_needs_tick, in_valid && in_ready && (cmd != CMD_TICK), !update_event, "update event without a tick")

    // a stalled result holds
    `PWM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(pwm_out) && $stable(pwm_out_inv) && $stable(update_event) && $stable(period_now), "stalled result changed")

endmodule

bind multi_channel_pwm_timer mcpt_checker u_mcpt_checker (.*);

`default_nettype wire

// ===== dv/multi_channel_pwm_timer_test.sv =====
module multi_channel_pwm_timer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpt_pkg::*;

    // clock shape and run bounds
    localparam int          CLK_HIGH_NS   = 10;
    localparam int          CLK_LOW_NS    = 10;
    localparam int          RESET_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 2;      // result shows in the cycle after accept
    localparam int          DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_ITEMS  = 1725;

    localparam int NUM_CH = DEF_CHANNELS;
    localparam int CNT_W  = DEF_COUNT_WIDTH;

    // command code with no function in the block
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // one result of the timer as seen on the output channel
    typedef struct packed {
        logic [PWM_W-1:0]        pwm;
        logic [PWM_W-1:0]        pwm_inv;
        logic                    update;
        logic [PERIOD_NOW_W-1:0] period;
    } pwm_result_t;

    // one line of the directed script: a register write or a request
    typedef struct packed {
        logic                   to_register;
        cfg_idx_t               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [CMD_W-1:0]       op;
        logic [CHAN_IDX_W-1:0]  ch;
        logic [VALUE_W-1:0]     val;
        logic                   typed;
        pwm_result_t            typed_result;
    } script_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    localparam pwm_result_t NO_RESULT = '0;

    // directed script
    // opening rows run with reset masks, so every output is low and the result
    // is easy to type in; the rest go through the timer model
    localparam int SCRIPT_LEN = 31;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // first tick after reset: zero period wraps at once
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000,
          1'b1, '{4'h0, 4'h0, 1'b1, 16'h0000}},
        // period preload at its top value, read back at once
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_PERIOD, 2'd0, 16'hFFFF,
          1'b1, '{4'h0, 4'h0, 1'b0, 16'hFFFF}},
        // unused command leaves everything alone
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_SPARE, 2'd3, 16'hFFFF,
          1'b1, '{4'h0, 4'h0, 1'b0, 16'hFFFF}},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_PERIOD, 2'd0, 16'h0004,
          1'b1, '{4'h0, 4'h0, 1'b0, 16'h0004}},
        // active period still zero, so this tick wraps and loads period 4
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000,
          1'b1, '{4'h0, 4'h0, 1'b1, 16'h0004}},
        // all channels on, complements on, mixed polarity, no prescaling
        '{1'b1, CFG_ENABLE,     16'hFFFF, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b1, CFG_COMPLEMENT, 16'h000F, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b1, CFG_POLARITY,   16'h000A, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b1, CFG_PRESCALE,   16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        // zero duty, duty far above period, duty inside, duty just past period
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_DUTY, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_DUTY, 2'd1, 16'hFFFF, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_DUTY, 2'd2, 16'h0002, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_DUTY, 2'd3, 16'h0005, 1'b0, NO_RESULT},
        // count up to the period, wrap, duties go live
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd1, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd2, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd3, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'hFFFF, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        // zero period queued, then runs out the current period
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_PERIOD, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        // zero period: update on every counter step
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        // slowest prescaler, then a smaller one below the running count
        '{1'b1, CFG_PRESCALE, 16'hFFFF, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b1, CFG_PRESCALE, 16'h0001, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT},
        '{1'b0, CFG_PRESCALE, 16'h0000, CMD_TICK, 2'd0, 16'h0000, 1'b0, NO_RESULT}
    };

    // clock, reset and every block input start at known values
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CMD_W-1:0]       cmd      = '0;
    logic [CHAN_IDX_W-1:0]  channel  = '0;
    logic [VALUE_W-1:0]     value    = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PWM_W-1:0]        pwm_out;
    logic [PWM_W-1:0]        pwm_out_inv;
    logic                    update_event;
    logic [PERIOD_NOW_W-1:0] period_now;

    // timer model state, updated as requests are accepted
    logic [PRESCALE_W-1:0] prescale_div    = '0;
    logic [PWM_W-1:0]      enable_mask     = '0;
    logic [PWM_W-1:0]      polarity_bits   = '0;
    logic [PWM_W-1:0]      complement_mask = '0;
    logic [PRESCALE_W-1:0] tick_count      = '0;
    logic [CNT_W-1:0]      step_count      = '0;
    logic [CNT_W-1:0]      period_next     = '0;
    logic [CNT_W-1:0]      period_live     = '0;
    logic [CNT_W-1:0]      duty_next [NUM_CH] = '{default: '0};
    logic [CNT_W-1:0]      duty_live [NUM_CH] = '{default: '0};

    // pwm levels still owed by the block, oldest first
    pwm_result_t pending_levels [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;

    // receiver stall state
    ready_mode_t ready_mode    = READY_ALWAYS;
    int unsigned ready_hold    = 0;
    logic [7:0]  ready_pattern = 8'b1011_0110;

    multi_channel_pwm_timer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .channel      (channel),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_out      (pwm_out),
        .pwm_out_inv  (pwm_out_inv),
        .update_event (update_event),
        .period_now   (period_now)
    );

    always
    begin
        #CLK_HIGH_NS clk = 1'b1;
        #CLK_LOW_NS  clk = 1'b0;
    end

    // timer model: advance by one accepted request and give the levels it shows
    function automatic pwm_result_t timer_advance(logic [CMD_W-1:0] op,
                                                  logic [CHAN_IDX_W-1:0] ch,
                                                  logic [VALUE_W-1:0] val);
        pwm_result_t     res;
        logic [NUM_CH-1:0] level;
        res = '0;
        case (op)
            CMD_TICK:
            begin
                if (tick_count >= prescale_div)
                begin
                    tick_count = '0;
                    // counter step: wrap at or past the live period
                    if (step_count >= period_live)
                    begin
                        step_count  = '0;
                        res.update  = 1'b1;
                        period_live = period_next;
                        duty_live   = duty_next;
                    end
                    else
                    begin
                        step_count = step_count + 1'b1;
                    end
                end
                else
                begin
                    tick_count = tick_count + 1'b1;
                end
            end
            CMD_DUTY:
            begin
                if (ch < NUM_CH)
                    duty_next[ch] = val;
            end
            CMD_PERIOD:
            begin
                period_next = val;
            end
            default:
            begin
            end
        endcase
        // pwm mode 1: reference high while the count is below the duty
        for (int n = 0; n < NUM_CH; n++)
            level[n] = step_count < duty_live[n];
        res.pwm     = (level ^ polarity_bits) & enable_mask;
        res.pwm_inv = ~level & enable_mask & complement_mask;
        res.period  = period_next;
        return res;
    endfunction

    // send one request in the current burst, or open a new burst after a gap
    task automatic send_request(logic [CMD_W-1:0] op, logic [CHAN_IDX_W-1:0] ch,
                                logic [VALUE_W-1:0] val, logic typed,
                                pwm_result_t typed_result);
        pwm_result_t level;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= op;
        channel  <= ch;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted at this edge; the model moves in step with the block
        level = timer_advance(op, ch, val);
        pending_levels.push_back(typed ? typed_result : level);
    endtask

    // register write, only once the block has nothing left in flight
    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PRESCALE:   prescale_div    = data;
            CFG_ENABLE:     enable_mask     = data[PWM_W-1:0];
            CFG_POLARITY:   polarity_bits   = data[PWM_W-1:0];
            CFG_COMPLEMENT: complement_mask = data[PWM_W-1:0];
        endcase
        burst_left = 0;
    endtask

    // mask data: all clear, all set, or random with junk in the upper bits
    function automatic logic [CFG_DATA_W-1:0] pick_mask_data();
        case ($urandom_range(0, 19))
            0, 1, 2: return '0;
            3, 4, 5: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0d ns: %s expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // receiver: ready pattern changes mode every so often
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(16, 160);
        end
        else
        begin
            ready_hold <= ready_hold - 1;
        end
        ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
        case (ready_mode)
            READY_ALWAYS:  out_ready <= 1'b1;
            READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
            READY_PATTERN: out_ready <= ready_pattern[7];
            READY_SPARSE:  out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // result checking against the oldest owed levels
    always @(posedge clk)
    begin : result_check
        pwm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0d ns: result with no request owed: expected none, got %0h %0h %0h %0h",
                         $time, pwm_out, pwm_out_inv, update_event, period_now);
                mismatch_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                check_field("pwm_out", 32'(want.pwm), 32'(pwm_out));
                check_field("pwm_out_inv", 32'(want.pwm_inv), 32'(pwm_out_inv));
                check_field("update_event", 32'(want.update), 32'(update_event));
                check_field("period_now", 32'(want.period), 32'(period_now));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("multi_channel_pwm_timer test failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned          sent;
        int unsigned          round_len;
        int                   roll;
        logic [PRESCALE_W-1:0] divide;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed script
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            if (SCRIPT[r].to_register)
                write_register(SCRIPT[r].reg_idx, SCRIPT[r].reg_data);
            else
                send_request(SCRIPT[r].op, SCRIPT[r].ch, SCRIPT[r].val,
                             SCRIPT[r].typed, SCRIPT[r].typed_result);
        end

        // random rounds, each with fresh register settings
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // prescaler mostly small so the counter actually wraps
            case ($urandom_range(0, 9))
                0:       divide = '1;
                1:       divide = PRESCALE_W'($urandom);
                2, 3:    divide = PRESCALE_W'($urandom_range(3, 7));
                default: divide = PRESCALE_W'($urandom_range(0, 2));
            endcase
            write_register(CFG_PRESCALE, divide);
            write_register(CFG_ENABLE, pick_mask_data());
            write_register(CFG_POLARITY, pick_mask_data());
            write_register(CFG_COMPLEMENT, pick_mask_data());

            round_len = $urandom_range(60, 200);
            for (int k = 0; k < round_len; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    // tick with junk in the unused fields
                    send_request(CMD_TICK, CHAN_IDX_W'($urandom), VALUE_W'($urandom),
                                 1'b0, NO_RESULT);
                    sent++;
                end
                else if (roll < 85)
                begin
                    // duty mostly near the small periods, sometimes anywhere
                    send_request(CMD_DUTY, CHAN_IDX_W'($urandom),
                                 ($urandom_range(0, 4) == 0) ? VALUE_W'($urandom)
                                                             : VALUE_W'($urandom_range(0, 16)),
                                 1'b0, NO_RESULT);
                    sent++;
                end
                else if (roll < 95)
                begin
                    send_request(CMD_PERIOD, CHAN_IDX_W'($urandom),
                                 VALUE_W'($urandom_range(0, 12)), 1'b0, NO_RESULT);
                    sent++;
                end
                else if (roll < 97)
                begin
                    // wide period overwritten before any tick can load it,
                    // otherwise the counter would stall for the rest of the run
                    send_request(CMD_PERIOD, CHAN_IDX_W'($urandom), VALUE_W'($urandom),
                                 1'b0, NO_RESULT);
                    send_request(CMD_PERIOD, CHAN_IDX_W'($urandom),
                                 VALUE_W'($urandom_range(0, 12)), 1'b0, NO_RESULT);
                    sent += 2;
                end
                else
                begin
                    send_request(CMD_SPARE, CHAN_IDX_W'($urandom), VALUE_W'($urandom),
                                 1'b0, NO_RESULT);
                    sent++;
                end
            end
        end
        in_valid <= 1'b0;

        // let every owed result come out, then idle for the drain period
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("multi_channel_pwm_timer test passed");
        else
            $display("multi_channel_pwm_timer test failed");
        $finish;
    end

endmodule
